>>> hdl/rle16_pkg.sv
package rle16_pkg;

    // Fixed field widths.
    localparam int BYTE_W  = 8;
    localparam int PIX_W   = 16;
    localparam int FRAME_W = 24;
    localparam int GRP_W   = 8;

    // Longest repeat run; a header of 0x80 replays the last run of this length.
    localparam int RUN_MAX = 128;

    // Default width of the pixel counter.
    localparam int COUNT_BITS_DEF = 24;

    // Header byte that replays the last full-length run.
    localparam logic [BYTE_W-1:0] HDR_REPEAT_LAST = 8'h80;

    // Frame length after reset.
    localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = 24'd1;

    // Byte parser phase.
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LIT_LO,
        PH_LIT_HI,
        PH_RUN_LO,
        PH_RUN_HI
    } phase_t;

    // Sequencer state.
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctl_state_t;

endpackage

>>> hdl/rle16_if.sv
// Encoded byte stream.
interface rle16_byte_if;
    import rle16_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rle_byte;

    modport source (output valid, output rle_byte, input ready);
    modport sink   (input valid, input rle_byte, output ready);
endinterface

// Decoded pixel results.
interface rle16_pix_if;
    import rle16_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_a;
    logic [PIX_W-1:0] pixel_b;
    logic [1:0]       pixel_count;
    logic             run_last;
    logic             frame_last;

    modport source (output valid, output pixel_a, output pixel_b, output pixel_count,
                    output run_last, output frame_last, input ready);
    modport sink   (input valid, input pixel_a, input pixel_b, input pixel_count,
                    input run_last, input frame_last, output ready);
endinterface

// Frame length register writes.
interface rle16_cfg_if;
    import rle16_pkg::*;

    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_pixels;

    modport source (output valid, output frame_pixels, input ready);
    modport sink   (input valid, input frame_pixels, output ready);
endinterface

>>> hdl/rle16_pixel_decoder.sv
// A byte completing a literal pixel, a repeat run or a replay header moves the sequencer
// to its emit state, which loads the first result once the output is free; input is not
// ready meanwhile. Other bytes give no result. Throughput: one byte per cycle while no
// pixels are due; a run gives pixel pairs while run and frame allow, a literal one pixel.
// The single add/compare unit retires one result per cycle while the output is not held.
// Reset (rst_n, async, active low) clears the parser and sets the frame length to 1.
module rle16_pixel_decoder
    #(
        parameter int COUNT_BITS = rle16_pkg::COUNT_BITS_DEF
    )
    (
        input  logic                 clk,
        input  logic                 rst_n,
        rle16_byte_if.sink           enc,
        rle16_pix_if.source          pix,
        rle16_cfg_if.sink            cfg
    );
    import rle16_pkg::*;

    // Control state.
    ctl_state_t             state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [GRP_W-1:0]       grp_reg, grp_next;
    logic [BYTE_W-1:0]      low_reg, low_next;
    logic [PIX_W-1:0]       last_run_reg, last_run_next;
    logic [COUNT_BITS-1:0]  done_reg, done_next;
    logic [FRAME_W-1:0]     frame_pixels_reg, frame_pixels_next;
    logic [GRP_W-1:0]       emit_cnt_reg, emit_cnt_next;
    logic                   emit_ends_reg, emit_ends_next;
    logic [PIX_W-1:0]       emit_val_reg, emit_val_next;
    logic                   out_valid_reg, out_valid_next;

    // Result payload.
    logic [PIX_W-1:0]       pix_a_reg, pix_a_next;
    logic [PIX_W-1:0]       pix_b_reg, pix_b_next;
    logic [1:0]             pix_cnt_reg, pix_cnt_next;
    logic                   run_last_reg, run_last_next;
    logic                   frame_last_reg, frame_last_next;

    // Shared counter unit.
    logic [FRAME_W+COUNT_BITS-1:0] fp_wide;
    logic [COUNT_BITS-1:0]  fp_masked;
    logic [COUNT_BITS-1:0]  fp;
    logic [COUNT_BITS:0]    done_p1;
    logic [COUNT_BITS:0]    done_p2;
    logic                   take2;
    logic [COUNT_BITS-1:0]  done_new;
    logic                   frame_end;
    logic [GRP_W-1:0]       cnt_after;

    logic                   in_fire;
    logic                   emit_fire;
    logic [PIX_W-1:0]       in_pixel;
    logic [GRP_W-1:0]       grp_dec;

    assign enc.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign in_fire   = enc.valid && enc.ready;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || pix.ready);
    assign in_pixel  = {enc.rle_byte, low_reg};
    assign grp_dec   = (grp_reg != '0) ? grp_reg - GRP_W'(1) : grp_reg;

    // Frame length kept to the counter width; zero counts as one.
    assign fp_wide   = {{COUNT_BITS{1'b0}}, frame_pixels_reg};
    assign fp_masked = fp_wide[COUNT_BITS-1:0];
    assign fp        = (fp_masked == '0) ? COUNT_BITS'(1) : fp_masked;

    // One result step: take two pixels if the run and the frame both allow it.
    assign done_p1   = {1'b0, done_reg} + (COUNT_BITS+1)'(1);
    assign done_p2   = {1'b0, done_reg} + (COUNT_BITS+1)'(2);
    assign take2     = (emit_cnt_reg >= GRP_W'(2)) && (done_p2 <= {1'b0, fp});
    assign done_new  = take2 ? done_p2[COUNT_BITS-1:0] : done_p1[COUNT_BITS-1:0];
    assign frame_end = (done_new >= fp) || (done_new == '0);
    assign cnt_after = emit_cnt_reg - (take2 ? GRP_W'(2) : GRP_W'(1));

    // Sequencer, parser and result formation.
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        grp_next          = grp_reg;
        low_next          = low_reg;
        last_run_next     = last_run_reg;
        done_next         = done_reg;
        frame_pixels_next = frame_pixels_reg;
        emit_cnt_next     = emit_cnt_reg;
        emit_ends_next    = emit_ends_reg;
        emit_val_next     = emit_val_reg;
        out_valid_next    = out_valid_reg;
        pix_a_next        = pix_a_reg;
        pix_b_next        = pix_b_reg;
        pix_cnt_next      = pix_cnt_reg;
        run_last_next     = run_last_reg;
        frame_last_next   = frame_last_reg;

        if (cfg.valid)
        begin
            frame_pixels_next = cfg.frame_pixels;
        end

        // The consumer took the held result.
        if (out_valid_reg && pix.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (phase_reg)
                        PH_LIT_LO:
                        begin
                            low_next   = enc.rle_byte;
                            phase_next = PH_LIT_HI;
                        end
                        PH_LIT_HI:
                        begin
                            grp_next       = grp_dec;
                            phase_next     = (grp_dec == '0) ? PH_HEADER : PH_LIT_LO;
                            emit_val_next  = in_pixel;
                            emit_cnt_next  = GRP_W'(1);
                            emit_ends_next = (grp_dec == '0);
                            state_next     = ST_EMIT;
                        end
                        PH_RUN_LO:
                        begin
                            low_next   = enc.rle_byte;
                            phase_next = PH_RUN_HI;
                        end
                        PH_RUN_HI:
                        begin
                            grp_next       = '0;
                            phase_next     = PH_HEADER;
                            emit_val_next  = in_pixel;
                            emit_cnt_next  = grp_reg;
                            emit_ends_next = 1'b1;
                            if (grp_reg == GRP_W'(RUN_MAX))
                            begin
                                last_run_next = in_pixel;
                            end
                            if (grp_reg != '0)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HEADER;
                            if (!enc.rle_byte[BYTE_W-1])
                            begin
                                grp_next   = enc.rle_byte + GRP_W'(1);
                                phase_next = PH_LIT_LO;
                            end
                            else if (enc.rle_byte == HDR_REPEAT_LAST)
                            begin
                                emit_val_next  = last_run_reg;
                                emit_cnt_next  = GRP_W'(RUN_MAX);
                                emit_ends_next = 1'b1;
                                state_next     = ST_EMIT;
                            end
                            else
                            begin
                                grp_next   = GRP_W'(9'd257 - {1'b0, enc.rle_byte});
                                phase_next = PH_RUN_LO;
                            end
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next  = 1'b1;
                    pix_a_next      = emit_val_reg;
                    pix_b_next      = take2 ? emit_val_reg : '0;
                    pix_cnt_next    = take2 ? 2'd2 : 2'd1;
                    run_last_next   = ((cnt_after == '0) && emit_ends_reg) || frame_end;
                    frame_last_next = frame_end;
                    emit_cnt_next   = cnt_after;
                    done_next       = done_new;
                    if (frame_end)
                    begin
                        // Frame complete: clear all parser state.
                        phase_next    = PH_HEADER;
                        grp_next      = '0;
                        low_next      = '0;
                        last_run_next = '0;
                        done_next     = '0;
                        emit_cnt_next = '0;
                        state_next    = ST_IDLE;
                    end
                    else if (cnt_after == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_HEADER;
            grp_reg          <= '0;
            low_reg          <= '0;
            last_run_reg     <= '0;
            done_reg         <= '0;
            frame_pixels_reg <= FRAME_PIXELS_RST;
            emit_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            grp_reg          <= grp_next;
            low_reg          <= low_next;
            last_run_reg     <= last_run_next;
            done_reg         <= done_next;
            frame_pixels_reg <= frame_pixels_next;
            emit_cnt_reg     <= emit_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        emit_ends_reg  <= emit_ends_next;
        emit_val_reg   <= emit_val_next;
        pix_a_reg      <= pix_a_next;
        pix_b_reg      <= pix_b_next;
        pix_cnt_reg    <= pix_cnt_next;
        run_last_reg   <= run_last_next;
        frame_last_reg <= frame_last_next;
    end

    // Result port.
    assign pix.valid       = out_valid_reg;
    assign pix.pixel_a     = pix_a_reg;
    assign pix.pixel_b     = pix_b_reg;
    assign pix.pixel_count = pix_cnt_reg;
    assign pix.run_last    = run_last_reg;
    assign pix.frame_last  = frame_last_reg;

    // A pending emission always has pixels left to send.
    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> emit_cnt_reg != '0)
        else $error("emission pending with zero pixels");

    // A result that ends the frame leaves the parser cleared.
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && frame_end |=> done_reg == '0 && phase_reg == PH_HEADER
            && state_reg == ST_IDLE)
        else $error("frame end did not clear state");

    // A pair always carries two copies of the run pixel.
    a_pair_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pix_cnt_reg == 2'd2 |-> pix_a_reg == pix_b_reg)
        else $error("pixel pair differs");

    // The end of a frame also ends the current group.
    a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_last_reg |-> run_last_reg)
        else $error("frame_last without run_last");

    // No input is taken while pixels are being emitted.
    a_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !enc.ready)
        else $error("input ready during emission");

endmodule
